[sv/pst_pkg.sv]
`default_nettype none

package pst_pkg;

    localparam int POS_W   = 28;
    localparam int COL_W   = 16;
    localparam int SCALE_W = 16;
    localparam int PROD_W  = 44;
    localparam int ARG_W   = 41;
    localparam int SINE_W  = 18;
    localparam int NOISE_W = 18;
    localparam int FADE_W  = 18;
    localparam int RAD_W   = 56;
    localparam int ROOT_W  = 28;
    localparam int DSQ_W   = 31;

    // pipeline depths of the sub-units, and root bits per square-root stage
    localparam int SQRT_STEP = 4;
    localparam int SQRT_STG  = ROOT_W / SQRT_STEP;
    localparam int NOISE_LAT = 6;
    localparam int BLEND_LAT = 2;

    // lattice weights per turn, only the low 16 bits reach the phase
    localparam logic [15:0] LAT_WX = 16'h3A85;
    localparam logic [15:0] LAT_WY = 16'h9BCD;
    localparam logic [15:0] LAT_WZ = 16'hE38E;

    localparam longint     HASH_MUL   = 64'd2867760026;
    localparam logic [21:0] INV_TWO_PI = 22'd2670177;
    localparam logic [32:0] DOT_LIMIT  = 33'd526133494;

    typedef enum logic [2:0] {
        MODE_PASS   = 3'd0,
        MODE_CHECK  = 3'd1,
        MODE_DOTS   = 3'd2,
        MODE_MARBLE = 3'd3,
        MODE_RINGS  = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        REG_MODE  = 3'd0,
        REG_SCALE = 3'd1,
        REG_SEC_R = 3'd2,
        REG_SEC_G = 3'd3,
        REG_SEC_B = 3'd4
    } t_reg_idx;

    typedef logic [2:0][COL_W-1:0] t_rgb;

    // quarter-wave sine polynomial, t in Q.16 over 0..1 of a quarter turn
    function automatic int quarter_poly(input longint unsigned t);
        longint unsigned t2;
        longint unsigned t3;
        longint unsigned t5;
        longint unsigned t7;
        longint          s;
        t2 = (t * t) >> 16;
        t3 = (t2 * t) >> 16;
        t5 = (t3 * t2) >> 16;
        t7 = (t5 * t2) >> 16;
        s  = longint'(64'd102944 * t) - longint'(64'd42334 * t3)
           + longint'(64'd5223 * t5) - longint'(64'd307 * t7);
        if (s < 0) begin
            s = 0;
        end
        s = s >>> 16;
        if (s > 65536) begin
            s = 65536;
        end
        return int'(s);
    endfunction

    // a + floor((b - a) * t / 2^16)
    function automatic logic signed [NOISE_W-1:0] mix_q16(
        input logic signed [NOISE_W-1:0] a,
        input logic signed [NOISE_W-1:0] b,
        input logic        [FADE_W-1:0]  t
    );
        logic signed [NOISE_W:0]  d;
        logic signed [2*NOISE_W+1:0] p;
        d = $signed({b[NOISE_W-1], b}) - $signed({a[NOISE_W-1], a});
        p = d * $signed({1'b0, t});
        return a + $signed(p[16 +: NOISE_W]);
    endfunction

endpackage

`default_nettype wire

[sv/pst_sine_rom.sv]
`default_nettype none

module pst_sine_rom #(
    parameter int DEPTH   = 1024,
    parameter bit IS_HASH = 1'b0
) (
    input  logic                          i_clk,
    input  logic [$clog2(DEPTH)-1:0]      i_addr,
    output logic [pst_pkg::SINE_W-1:0]    o_q
);

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int QUARTER = DEPTH / 4;

    logic [pst_pkg::SINE_W-1:0] w_tab [DEPTH];
    logic [pst_pkg::SINE_W-1:0] r_q;

    // entries are worked out at elaboration: sine in Q.16 or its lattice hash
    for (genvar g = 0; g < DEPTH; g++) begin : g_tab
        localparam int     QUAD = (g / QUARTER) % 4;
        localparam int     KK   = g % QUARTER;
        localparam int     KQ   = (QUAD % 2 == 1) ? QUARTER - KK : KK;
        localparam longint TQ   = (longint'(KQ) * 65536) / QUARTER;
        localparam int     MAG  = pst_pkg::quarter_poly(TQ);
        localparam int     SV   = (QUAD >= 2) ? -MAG : MAG;
        localparam longint HV   = ((longint'(SV) * pst_pkg::HASH_MUL) >>> 16) & 64'hFFFF;
        assign w_tab[g] = IS_HASH ? pst_pkg::SINE_W'(HV) : pst_pkg::SINE_W'(SV);
    end

    always_ff @(posedge i_clk) begin
        r_q <= w_tab[i_addr[IDX_W-1:0]];
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

[sv/pst_isqrt.sv]
`default_nettype none

module pst_isqrt (
    input  logic                         i_clk,
    input  logic [pst_pkg::RAD_W-1:0]    i_rad,
    output logic [pst_pkg::ROOT_W-1:0]   o_root
);

    localparam int NSTG  = pst_pkg::SQRT_STG;
    localparam int STEP  = pst_pkg::SQRT_STEP;
    localparam int RT_W  = pst_pkg::ROOT_W;
    localparam int RM_W  = pst_pkg::ROOT_W + 2;
    localparam int RD_W  = pst_pkg::RAD_W;

    logic [RM_W-1:0] r_rem  [NSTG];
    logic [RT_W-1:0] r_root [NSTG];
    logic [RD_W-1:0] r_rad  [NSTG];

    // digit-by-digit square root, STEP result bits per stage
    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic [RM_W-1:0] w_rem_in;
        logic [RT_W-1:0] w_root_in;
        logic [RD_W-1:0] w_rad_in;
        logic [RM_W-1:0] n_rem;
        logic [RT_W-1:0] n_root;
        logic [RD_W-1:0] n_rad;

        if (s == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = i_rad;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_root_in = r_root[s-1];
            assign w_rad_in  = r_rad[s-1];
        end

        always_comb begin
            n_rem  = w_rem_in;
            n_root = w_root_in;
            n_rad  = w_rad_in;
            for (int k = 0; k < STEP; k++) begin
                n_rem = {n_rem[RM_W-3:0], n_rad[RD_W-1 -: 2]};
                n_rad = {n_rad[RD_W-3:0], 2'b00};
                if (n_rem >= {n_root, 2'b01}) begin
                    n_rem  = n_rem - {n_root, 2'b01};
                    n_root = {n_root[RT_W-2:0], 1'b1};
                end else begin
                    n_root = {n_root[RT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= n_rem;
            r_root[s] <= n_root;
            r_rad[s]  <= n_rad;
        end
    end

    assign o_root = r_root[NSTG-1];

endmodule

`default_nettype wire

[sv/pst_noise.sv]
`default_nettype none

module pst_noise #(
    parameter int DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic [31:0]                         i_vx,
    input  logic [31:0]                         i_vy,
    input  logic [31:0]                         i_vz,
    output logic signed [pst_pkg::NOISE_W-1:0]  o_n
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int NW    = pst_pkg::NOISE_W;
    localparam int FW    = pst_pkg::FADE_W;

    logic [2:0][31:0] w_v;
    logic [2:0][31:0] w_ff;
    logic [2:0][33:0] w_fp;

    logic [2:0][15:0]   r_fsq;
    logic [2:0][FW-1:0] r_fk;
    logic [15:0]        r_ph0;
    logic [2:0][FW-1:0] r_fade2;
    logic [2:0][FW-1:0] r_fade3;
    logic [1:0][FW-1:0] r_fade4;
    logic [FW-1:0]      r_fz5;

    logic [7:0][15:0]          w_hash;
    logic signed [NW-1:0]      r_mx [4];
    logic signed [NW-1:0]      r_my [2];
    logic signed [NW-1:0]      r_n;

    assign w_v = {i_vz, i_vy, i_vx};

    // stage 1: fade square, fade slope, base lattice phase
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_ff[c] = {16'd0, w_v[c][15:0]} * {16'd0, w_v[c][15:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_fsq[c] <= w_ff[c][31:16];
            r_fk[c]  <= FW'(196608) - {1'b0, w_v[c][15:0], 1'b0};
        end
        r_ph0 <= w_v[0][31:16] * pst_pkg::LAT_WX + w_v[1][31:16] * pst_pkg::LAT_WY
               + w_v[2][31:16] * pst_pkg::LAT_WZ;
    end

    // stage 2: smoothstep weights
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_fp[c] = {16'd0, r_fsq[c]} * {16'd0, r_fk[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_fade2[c] <= w_fp[c][16 +: FW];
        end
        r_fade3 <= r_fade2;
        r_fade4 <= {r_fade3[2], r_fade3[1]};
        r_fz5   <= r_fade4[1];
    end

    // stages 2 and 3: corner phase to table index, hash table read
    for (genvar c = 0; c < 8; c++) begin : g_cor
        localparam logic [15:0] OFS = 16'(((c & 1) * pst_pkg::LAT_WX)
                                        + (((c >> 1) & 1) * pst_pkg::LAT_WY)
                                        + (((c >> 2) & 1) * pst_pkg::LAT_WZ));
        logic [15:0]               w_ph;
        logic [16+IDX_W-1:0]       w_p;
        logic [IDX_W-1:0]          r_idx;
        logic [pst_pkg::SINE_W-1:0] w_q;

        assign w_ph = r_ph0 + OFS;
        assign w_p  = {{IDX_W{1'b0}}, w_ph} * (16+IDX_W)'(DEPTH);

        always_ff @(posedge i_clk) begin
            r_idx <= w_p[16 +: IDX_W];
        end

        pst_sine_rom #(
            .DEPTH   (DEPTH),
            .IS_HASH (1'b1)
        ) u_hash (
            .i_clk  (i_clk),
            .i_addr (r_idx),
            .o_q    (w_q)
        );

        assign w_hash[c] = w_q[15:0];
    end

    // stages 4 to 6: trilinear interpolation, x then y then z
    always_ff @(posedge i_clk) begin
        for (int m = 0; m < 4; m++) begin
            r_mx[m] <= pst_pkg::mix_q16($signed({2'b00, w_hash[2*m]}),
                                        $signed({2'b00, w_hash[2*m+1]}), r_fade3[0]);
        end
        r_my[0] <= pst_pkg::mix_q16(r_mx[0], r_mx[1], r_fade4[0]);
        r_my[1] <= pst_pkg::mix_q16(r_mx[2], r_mx[3], r_fade4[0]);
        r_n     <= pst_pkg::mix_q16(r_my[0], r_my[1], r_fz5);
    end

    assign o_n = r_n;

endmodule

`default_nettype wire

[sv/pst_blend.sv]
`default_nettype none

module pst_blend (
    input  logic                                i_clk,
    input  logic signed [pst_pkg::SINE_W-1:0]   i_sine,
    input  pst_pkg::t_rgb                       i_c1,
    input  pst_pkg::t_rgb                       i_sec,
    output pst_pkg::t_rgb                       o_col
);

    logic [18:0]      w_sp;
    logic [16:0]      w_w;
    logic [16:0]      w_wn;
    logic [2:0][32:0] r_pa;
    logic [2:0][32:0] r_pb;
    logic [2:0][33:0] w_sum;
    pst_pkg::t_rgb    r_col;

    // weight (sine + 1) / 2 in Q.16
    assign w_sp = 19'($signed({i_sine[pst_pkg::SINE_W-1], i_sine}) + 19'sd65536);
    assign w_w  = w_sp[17:1];
    assign w_wn = 17'd65536 - w_w;

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_pa[c] <= {17'd0, i_c1[c]} * {16'd0, w_w};
            r_pb[c] <= {17'd0, i_sec[c]} * {16'd0, w_wn};
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_sum[c] = {1'b0, r_pa[c]} + {1'b0, r_pb[c]} + 34'd32768;
        end
    end

    // round and saturate
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            if (w_sum[c][33:32] != 2'b00) begin
                r_col[c] <= '1;
            end else begin
                r_col[c] <= w_sum[c][31:16];
            end
        end
    end

    assign o_col = r_col;

endmodule

`default_nettype wire

[sv/procedural_solid_texture.sv]
`default_nettype none

// Procedural solid texture: one sample (hit point plus primary colour) can be
// taken every clock cycle, and its textured colour appears on o_out_r/g/b
// with o_strobe at the end of the pipeline. The latency is set by the
// ring path: squares, a seven-stage square root (four root bits per
// stage), scale multiply to phase, table index, the registered sine
// table read, and the two-stage colour blend; all other modes are delayed to
// match. There is no back-pressure: results must be taken when strobed.
// busy is high only while reset is held. Registers on the cfg port are
// always ready but may be written only when no sample is in flight.
module procedural_solid_texture #(
    parameter int COORD_FRAC_BITS  = 16,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              start,
    output logic                              busy,
    input  logic signed [pst_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [pst_pkg::POS_W-1:0]  i_pos_y,
    input  logic signed [pst_pkg::POS_W-1:0]  i_pos_z,
    input  logic [pst_pkg::COL_W-1:0]         i_prim_r,
    input  logic [pst_pkg::COL_W-1:0]         i_prim_g,
    input  logic [pst_pkg::COL_W-1:0]         i_prim_b,

    output logic                              o_strobe,
    output logic [pst_pkg::COL_W-1:0]         o_out_r,
    output logic [pst_pkg::COL_W-1:0]         o_out_g,
    output logic [pst_pkg::COL_W-1:0]         o_out_b,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [2:0]                        i_cfg_idx,
    input  logic [15:0]                       i_cfg_data
);

    localparam int SH      = COORD_FRAC_BITS - 8;
    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
    localparam int PW      = pst_pkg::PROD_W;
    localparam int AW      = pst_pkg::ARG_W;

    localparam int ST_N    = 1 + pst_pkg::NOISE_LAT;
    localparam int ST_ARG  = ST_N + 1;
    localparam int ST_MPH  = ST_ARG + 1;
    localparam int ST_MIDX = ST_MPH + 1;
    localparam int ST_ROOT = 2 + pst_pkg::SQRT_STG;
    localparam int ST_RPH  = ST_ROOT + 1;
    localparam int ST_RIDX = ST_RPH + 1;
    localparam int ST_SINE = ST_RIDX + 1;
    localparam int ST_MIX  = ST_SINE + pst_pkg::BLEND_LAT;
    localparam int LAT     = ST_MIX + 1;

    // configuration registers
    logic [2:0]                  r_mode;
    logic [pst_pkg::SCALE_W-1:0] r_scale;
    pst_pkg::t_rgb               r_sec;

    logic w_acc;

    logic [2:0][pst_pkg::POS_W-1:0] w_pos;
    logic signed [PW:0]             w_ps [3];
    logic signed [2*pst_pkg::POS_W-1:0] w_sqx;
    logic signed [2*pst_pkg::POS_W-1:0] w_sqz;

    logic [LAT:1]                   r_vld;
    logic signed [PW-1:0]           r_u [3];
    logic [pst_pkg::RAD_W-1:0]      r_sqx;
    logic [pst_pkg::RAD_W-1:0]      r_sqz;
    pst_pkg::t_rgb                  r_c1 [1:ST_MIX];
    logic                           r_chk [2:ST_MIX];
    logic                           r_dot [3:ST_MIX];
    logic [pst_pkg::DSQ_W-1:0]      r_dsq [3];
    logic [pst_pkg::RAD_W-1:0]      r_rad;
    logic [AW-1:0]                  r_usum [2:ST_N];

    logic signed [16:0]             w_d [3];
    logic signed [33:0]             w_dd [3];

    logic signed [pst_pkg::NOISE_W-1:0] w_n;
    logic [AW-1:0]                  w_n41;
    logic [AW-1:0]                  r_arg;
    logic [AW+21:0]                 w_am;
    logic [15:0]                    r_mph;
    logic [16+IDX_W-1:0]            w_mi;
    logic [IDX_W-1:0]               r_midx [ST_MIDX:ST_RIDX];

    logic [pst_pkg::ROOT_W-1:0]     w_root;
    logic [PW-1:0]                  w_rs;
    logic [15:0]                    r_rph;
    logic [16+IDX_W-1:0]            w_ri;
    logic [IDX_W-1:0]               r_ridx;

    logic [IDX_W-1:0]               w_saddr;
    logic [pst_pkg::SINE_W-1:0]     w_sine;
    pst_pkg::t_rgb                  w_blend;
    pst_pkg::t_rgb                  r_out;

    assign busy        = ~i_rst_n;
    assign w_acc       = start & ~busy;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= pst_pkg::MODE_PASS;
            r_scale <= 16'd256;
            r_sec   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_idx)
                pst_pkg::REG_MODE:  r_mode   <= i_cfg_data[2:0];
                pst_pkg::REG_SCALE: r_scale  <= i_cfg_data;
                pst_pkg::REG_SEC_R: r_sec[0] <= i_cfg_data;
                pst_pkg::REG_SEC_G: r_sec[1] <= i_cfg_data;
                pst_pkg::REG_SEC_B: r_sec[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits travel with the samples
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-1:1], w_acc};
        end
    end

    // stage 1: scaled coordinates and squares for the ring radius
    assign w_pos = {i_pos_z, i_pos_y, i_pos_x};

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_ps[c] = $signed(w_pos[c]) * $signed({1'b0, r_scale});
        end
    end

    assign w_sqx = i_pos_x * i_pos_x;
    assign w_sqz = i_pos_z * i_pos_z;

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_u[c] <= PW'(w_ps[c] >>> SH);
        end
        r_sqx   <= w_sqx;
        r_sqz   <= w_sqz;
    end

    // stage 2: dot distance squares, radius squared
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_d[c]  = $signed({1'b0, r_u[c][15:0]}) - 17'sd32768;
            w_dd[c] = w_d[c] * w_d[c];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_dsq[c] <= w_dd[c][pst_pkg::DSQ_W-1:0];
        end
        r_rad     <= r_sqx + r_sqz;
    end

    // side data delay lines, each loaded at its first stage
    always_ff @(posedge i_clk) begin
        r_c1[1]   <= {i_prim_b, i_prim_g, i_prim_r};
        // checker parity
        r_chk[2]  <= ~(r_u[0][16] ^ r_u[1][16] ^ r_u[2][16]);
        r_usum[2] <= r_u[0][AW-1:0] + r_u[2][AW-1:0];
        // dot threshold
        r_dot[3]  <= ({2'b00, r_dsq[0]} + {2'b00, r_dsq[1]} + {2'b00, r_dsq[2]})
                     >= pst_pkg::DOT_LIMIT;
        r_midx[ST_MIDX] <= w_mi[16 +: IDX_W];
        for (int k = 2; k <= ST_MIX; k++) begin
            r_c1[k] <= r_c1[k-1];
        end
        for (int k = 3; k <= ST_MIX; k++) begin
            r_chk[k] <= r_chk[k-1];
        end
        for (int k = 4; k <= ST_MIX; k++) begin
            r_dot[k] <= r_dot[k-1];
        end
        for (int k = 3; k <= ST_N; k++) begin
            r_usum[k] <= r_usum[k-1];
        end
        for (int k = ST_MIDX + 1; k <= ST_RIDX; k++) begin
            r_midx[k] <= r_midx[k-1];
        end
    end

    // marble: value noise on half the scaled coordinate
    pst_noise #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_noise (
        .i_clk (i_clk),
        .i_vx  (r_u[0][32:1]),
        .i_vy  (r_u[1][32:1]),
        .i_vz  (r_u[2][32:1]),
        .o_n   (w_n)
    );

    assign w_n41 = {{(AW - pst_pkg::NOISE_W){w_n[pst_pkg::NOISE_W-1]}}, w_n};
    assign w_am  = {22'd0, r_arg} * {{AW{1'b0}}, pst_pkg::INV_TWO_PI};
    assign w_mi  = {{IDX_W{1'b0}}, r_mph} * (16+IDX_W)'(SINE_TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        r_arg          <= r_usum[ST_N] + (r_usum[ST_N] << 1) + (w_n41 << 1) + (w_n41 << 2);
        r_mph          <= w_am[40:25];
    end

    // rings: radius in the coordinate format
    pst_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_rad  (r_rad),
        .o_root (w_root)
    );

    assign w_rs = {16'd0, w_root} * {28'd0, r_scale};
    assign w_ri = {{IDX_W{1'b0}}, r_rph} * (16+IDX_W)'(SINE_TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        r_rph  <= w_rs[SH +: 16];
        r_ridx <= w_ri[16 +: IDX_W];
    end

    // shared sine lookup and blend
    assign w_saddr = (r_mode == pst_pkg::MODE_RINGS) ? r_ridx : r_midx[ST_RIDX];

    pst_sine_rom #(
        .DEPTH   (SINE_TABLE_DEPTH),
        .IS_HASH (1'b0)
    ) u_sine (
        .i_clk  (i_clk),
        .i_addr (w_saddr),
        .o_q    (w_sine)
    );

    pst_blend u_blend (
        .i_clk  (i_clk),
        .i_sine ($signed(w_sine)),
        .i_c1   (r_c1[ST_SINE]),
        .i_sec  (r_sec),
        .o_col  (w_blend)
    );

    // output select
    always_ff @(posedge i_clk) begin
        case (r_mode)
            pst_pkg::MODE_CHECK:  r_out <= r_chk[ST_MIX] ? r_sec : r_c1[ST_MIX];
            pst_pkg::MODE_DOTS:   r_out <= r_dot[ST_MIX] ? r_sec : r_c1[ST_MIX];
            pst_pkg::MODE_MARBLE: r_out <= w_blend;
            pst_pkg::MODE_RINGS:  r_out <= w_blend;
            default:              r_out <= r_c1[ST_MIX];
        endcase
    end

    assign o_strobe = r_vld[LAT];
    assign o_out_r  = r_out[0];
    assign o_out_g  = r_out[1];
    assign o_out_b  = r_out[2];

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##LAT o_strobe)
        else $error("result strobe does not follow accepted transaction");

    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && r_mode == pst_pkg::MODE_PASS) |->
        (o_out_r == $past(i_prim_r, LAT) && o_out_g == $past(i_prim_g, LAT)
         && o_out_b == $past(i_prim_b, LAT)))
        else $error("pass-through colour mismatch");

    a_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && r_mode == pst_pkg::MODE_CHECK) |->
        (o_out_r == $past(i_prim_r, LAT) || o_out_r == r_sec[0]))
        else $error("checker colour is neither primary nor second");

endmodule

`default_nettype wire

[dv/tb_procedural_solid_texture.sv]
`timescale 1ns / 100ps

module tb_procedural_solid_texture;

    localparam logic [2:0] MODE_SPARE = 3'd5;
    localparam logic [2:0] IDX_SPARE  = 3'd7;
    localparam int         DRAIN_CYC  = 20;

    typedef struct {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
    } t_color;

    class texture_scoreboard;
        logic [2:0]  mode;
        logic [15:0] scale;
        logic [15:0] sec [3];
        t_color      colors_due [$];

        function new();
            mode  = pst_pkg::MODE_PASS;
            scale = 16'd256;
            foreach (sec[i]) sec[i] = 16'd0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                pst_pkg::REG_MODE:  mode = data[2:0];
                pst_pkg::REG_SCALE: scale = data;
                pst_pkg::REG_SEC_R: sec[0] = data;
                pst_pkg::REG_SEC_G: sec[1] = data;
                pst_pkg::REG_SEC_B: sec[2] = data;
                default: ;
            endcase
        endfunction

        // table sine: 1024 entries per turn, quarter-wave polynomial
        function longint sine_q16(longint unsigned phase);
            longint unsigned idx, quad, k, t, t2, t3, t5, t7;
            longint s;
            idx  = ((phase & 64'hFFFF) * 64'd1024) >> 16;
            quad = (idx / 64'd256) & 64'd3;
            k    = idx % 64'd256;
            if (quad[0]) k = 64'd256 - k;
            t  = (k * 64'd65536) / 64'd256;
            t2 = (t * t) >> 16;
            t3 = (t2 * t) >> 16;
            t5 = (t3 * t2) >> 16;
            t7 = (t5 * t2) >> 16;
            s  = longint'(64'd102944 * t) - longint'(64'd42334 * t3)
               + longint'(64'd5223 * t5) - longint'(64'd307 * t7);
            if (s < 0) s = 0;
            s = s >>> 16;
            if (s > 65536) s = 65536;
            return (quad >= 2) ? -s : s;
        endfunction

        function longint corner_hash(longint i, longint j, longint k);
            longint unsigned ph;
            longint          sv;
            ph = longint'(unsigned'(i)) * 64'd1325701 + longint'(unsigned'(j)) * 64'd3251149
               + longint'(unsigned'(k)) * 64'd779150;
            sv = sine_q16(ph & 64'hFFFF);
            return longint'(((longint'(unsigned'(sv)) * 64'd2867760026) >> 16) & 64'hFFFF);
        endfunction

        function longint smooth(longint unsigned f);
            longint unsigned sq;
            sq = (f * f) >> 16;
            return longint'((sq * (64'd196608 - 64'd2 * f)) >> 16);
        endfunction

        function longint lerp(longint a, longint b, longint t);
            return a + (((b - a) * t) >>> 16);
        endfunction

        function longint value_noise(longint vx, longint vy, longint vz);
            longint ix, iy, iz, fx, fy, fz, a, b, a2, b2;
            longint h [8];
            ix = vx >>> 16;
            iy = vy >>> 16;
            iz = vz >>> 16;
            fx = smooth(vx & 64'hFFFF);
            fy = smooth(vy & 64'hFFFF);
            fz = smooth(vz & 64'hFFFF);
            for (int n = 0; n < 8; n++)
                h[n] = corner_hash(ix + (n & 1), iy + ((n >> 1) & 1), iz + ((n >> 2) & 1));
            a  = lerp(h[0], h[1], fx);
            b  = lerp(h[2], h[3], fx);
            a2 = lerp(h[4], h[5], fx);
            b2 = lerp(h[6], h[7], fx);
            return lerp(lerp(a, b, fy), lerp(a2, b2, fy), fz);
        endfunction

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned r, trial;
            r = 0;
            for (int i = 31; i >= 0; i--) begin
                trial = r | (64'd1 << i);
                if (trial * trial <= v) r = trial;
            end
            return r;
        endfunction

        function t_color sine_mix(logic [15:0] c1 [3], longint sv);
            longint unsigned w, v;
            logic [15:0]     o [3];
            t_color          res;
            w = longint'(unsigned'(sv + 65536)) >> 1;
            for (int ch = 0; ch < 3; ch++) begin
                v = (64'(c1[ch]) * w + 64'(sec[ch]) * (64'd65536 - w) + 64'd32768) >> 16;
                o[ch] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
            end
            res.r = o[0];
            res.g = o[1];
            res.b = o[2];
            return res;
        endfunction

        function void note_sample(longint px, longint py, longint pz,
                                  logic [15:0] cr, logic [15:0] cg, logic [15:0] cb);
            longint          p [3];
            longint          u [3];
            logic [15:0]     c1 [3];
            longint unsigned acc, ph;
            longint          d, n, arg;
            t_color          res;
            p[0] = px;
            p[1] = py;
            p[2] = pz;
            c1[0] = cr;
            c1[1] = cg;
            c1[2] = cb;
            for (int ch = 0; ch < 3; ch++) u[ch] = (p[ch] * longint'(scale)) >>> 8;
            res.r = cr;
            res.g = cg;
            res.b = cb;
            case (mode)
                pst_pkg::MODE_CHECK: begin
                    acc = longint'(unsigned'(u[0] >>> 16)) + longint'(unsigned'(u[1] >>> 16))
                        + longint'(unsigned'(u[2] >>> 16));
                    if (!acc[0]) begin
                        res.r = sec[0];
                        res.g = sec[1];
                        res.b = sec[2];
                    end
                end
                pst_pkg::MODE_DOTS: begin
                    acc = 0;
                    for (int ch = 0; ch < 3; ch++) begin
                        d = (u[ch] & 64'hFFFF) - 32768;
                        acc += longint'(unsigned'(d * d));
                    end
                    if (acc >= 64'd526133494) begin
                        res.r = sec[0];
                        res.g = sec[1];
                        res.b = sec[2];
                    end
                end
                pst_pkg::MODE_MARBLE: begin
                    n   = value_noise(u[0] >>> 1, u[1] >>> 1, u[2] >>> 1);
                    arg = 3 * (u[0] + u[2]) + 6 * n;
                    ph  = ((longint'(unsigned'(arg)) * 64'd2670177) >> 25) & 64'hFFFF;
                    res = sine_mix(c1, sine_q16(ph));
                end
                pst_pkg::MODE_RINGS: begin
                    acc = root_floor(longint'(unsigned'(p[0] * p[0]))
                                     + longint'(unsigned'(p[2] * p[2])));
                    ph  = ((acc * 64'(scale)) >> 8) & 64'hFFFF;
                    res = sine_mix(c1, sine_q16(ph));
                end
                default: ;
            endcase
            colors_due.push_back(res);
        endfunction

        // returns an empty string when the result matches
        function string check_result(logic [15:0] r, logic [15:0] g, logic [15:0] b);
            t_color e;
            if (colors_due.size() == 0)
                return $sformatf("unexpected result r=%h g=%h b=%h", r, g, b);
            e = colors_due.pop_front();
            if (r !== e.r || g !== e.g || b !== e.b)
                return $sformatf("got r=%h g=%h b=%h, want r=%h g=%h b=%h",
                                 r, g, b, e.r, e.g, e.b);
            return "";
        endfunction

        function int pending();
            return colors_due.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic signed [27:0] i_pos_x, i_pos_y, i_pos_z;
    logic [15:0]       i_prim_r, i_prim_g, i_prim_b;
    logic              o_strobe;
    logic [15:0]       o_out_r, o_out_g, o_out_b;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [2:0]        i_cfg_idx;
    logic [15:0]       i_cfg_data;

    texture_scoreboard sb;
    int                mismatch_cnt;
    bit                no_gaps;

    procedural_solid_texture DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_pos_z    (i_pos_z),
        .i_prim_r   (i_prim_r),
        .i_prim_g   (i_prim_g),
        .i_prim_b   (i_prim_b),
        .o_strobe   (o_strobe),
        .o_out_r    (o_out_r),
        .o_out_g    (o_out_g),
        .o_out_b    (o_out_b),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3ms;
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(string msg);
        mismatch_cnt++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // transaction monitors
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_idx, i_cfg_data);
            if (start && !busy)
                sb.note_sample(i_pos_x, i_pos_y, i_pos_z, i_prim_r, i_prim_g, i_prim_b);
            if (o_strobe) begin
                msg = sb.check_result(o_out_r, o_out_g, o_out_b);
                if (msg != "") report_mismatch(msg);
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_sample(logic [27:0] x, logic [27:0] y, logic [27:0] z,
                               logic [15:0] r, logic [15:0] g, logic [15:0] b);
        int gap;
        start    <= 1'b1;
        i_pos_x  <= x;
        i_pos_y  <= y;
        i_pos_z  <= z;
        i_prim_r <= r;
        i_prim_g <= g;
        i_prim_b <= b;
        do @(posedge i_clk); while (busy);
        if (!no_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    function automatic logic [27:0] rand_pos();
        case ($urandom_range(0, 3))
            0:       return 28'($urandom);
            1:       return 28'(int'($urandom_range(0, 2097152)) - 1048576);
            default: return 28'(int'($urandom_range(0, 262144)) - 131072);
        endcase
    endfunction

    function automatic logic [15:0] rand_scale();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(1, 2048));
        endcase
    endfunction

    task automatic send_random();
        send_sample(rand_pos(), rand_pos(), rand_pos(),
                    16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial begin
        logic [27:0] pmax, pmin;
        logic [2:0]  m;
        pmax = 28'h7FFFFFF;
        pmin = 28'h8000000;
        sb           = new();
        mismatch_cnt = 0;
        no_gaps      = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_idx    = pst_pkg::REG_MODE;
        i_cfg_data   = 16'd0;
        i_pos_x      = '0;
        i_pos_y      = '0;
        i_pos_z      = '0;
        i_prim_r     = '0;
        i_prim_g     = '0;
        i_prim_b     = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset registers, then every mode at field extremes
        send_sample(pmax, pmin, 28'd0, 16'hFFFF, 16'h0000, 16'h8000);
        drain();
        write_reg(pst_pkg::REG_SEC_R, 16'hFFFF);
        write_reg(pst_pkg::REG_SEC_G, 16'h1234);
        write_reg(pst_pkg::REG_SEC_B, 16'h0000);
        write_reg(IDX_SPARE, 16'h0003);
        for (int md = 0; md <= 5; md++) begin
            write_reg(pst_pkg::REG_MODE, 16'(md));
            write_reg(pst_pkg::REG_SCALE, 16'd256);
            send_sample(pmax, pmax, pmax, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            send_sample(pmin, pmin, pmin, 16'h0000, 16'h0000, 16'h0000);
            send_sample(28'h0008000, 28'h0008000, 28'h0008000, 16'hFFFF, 16'h0, 16'h1);
            drain();
            write_reg(pst_pkg::REG_SCALE, 16'h0000);
            send_sample(pmax, 28'h1234567, pmin, 16'h00FF, 16'hFF00, 16'h5A5A);
            drain();
            write_reg(pst_pkg::REG_SCALE, 16'hFFFF);
            send_sample(28'h0001000, pmin, 28'hFFFF000, 16'hFFFF, 16'h8000, 16'h0);
            drain();
        end
        write_reg(pst_pkg::REG_MODE, 16'(MODE_SPARE));
        send_sample(pmax, 28'd1, pmin, 16'h1111, 16'h2222, 16'h3333);
        drain();

        // random phases with fresh register settings in between
        for (int ph = 0; ph < 10; ph++) begin
            m = (ph < 8) ? 3'(ph % 5) : 3'($urandom_range(0, 7));
            if (ph == 9) no_gaps = 1'b1;
            write_reg(pst_pkg::REG_MODE, {13'($urandom), m});
            write_reg(pst_pkg::REG_SCALE, rand_scale());
            write_reg(pst_pkg::REG_SEC_R, 16'($urandom));
            write_reg(pst_pkg::REG_SEC_G, 16'($urandom));
            write_reg(pst_pkg::REG_SEC_B, 16'($urandom));
            for (int k = 0; k < 120; k++) begin
                send_random();
                // the sender holds off once until the pipeline is empty
                if (ph == 2 && k == 60) drain();
            end
            drain();
        end

        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatch_cnt == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
